// File: rtl/dwpr_pkg.sv
package dwpr_pkg;

  localparam int RING_AW    = 8;
  localparam int RING_DEPTH = 1 << RING_AW;
  localparam int LEVEL_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int ACTIN_W    = 16;
  localparam int SUM_W      = 40;
  localparam int FRAC_W     = 12;
  localparam int PROD_W     = SUM_W + GAIN_W;
  localparam int SCALED_W   = PROD_W - FRAC_W;
  localparam int CFG_IDX_W  = 8;

  typedef logic [RING_AW-1:0] ring_addr_t;
  typedef logic [RING_AW:0]   fill_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [GAIN_W-1:0]  gain_t;
  typedef logic [ACTIN_W-1:0] actin_t;
  typedef logic [SUM_W-1:0]   wsum_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_RECEPTOR_NORM  = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_RECEPTOR_FLOOR = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_NOTCH_GAIN     = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_LIGAND_GAIN    = cfg_idx_t'(3);
  localparam cfg_idx_t CFG_LIGAND_CEILING = cfg_idx_t'(4);
  localparam cfg_idx_t CFG_ACTIN_LIMIT    = cfg_idx_t'(5);

  localparam level_t RST_RECEPTOR_NORM  = level_t'(4096000);
  localparam level_t RST_RECEPTOR_FLOOR = '0;
  localparam gain_t  RST_NOTCH_GAIN     = gain_t'(4096);
  localparam gain_t  RST_LIGAND_GAIN    = gain_t'(4096);
  localparam level_t RST_LIGAND_CEILING = '1;
  localparam actin_t RST_ACTIN_LIMIT    = actin_t'(257);

  typedef struct packed {
    level_t receptor_norm;
    level_t receptor_floor;
    gain_t  notch_gain;
    gain_t  ligand_gain;
    level_t ligand_ceiling;
    actin_t actin_limit;
  } cfg_t;

  // push: a beat is written into the rings; pop: the front item leaves the ring stage.
  typedef struct packed {
    logic push;
    logic pop;
  } win_ctl_t;

endpackage

// File: rtl/dwpr_ram.sv
module dwpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/dwpr_window.sv
module dwpr_window import dwpr_pkg::*; #(
  parameter int DELAY  = 16,
  parameter int WINDOW = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  win_ctl_t   ctl,
  input  ring_addr_t ptr,
  input  fill_t      fill,
  input  level_t     x,
  output wsum_t      sum_o
);

  localparam fill_t ENTER_OFS = fill_t'(DELAY);
  localparam fill_t LEAVE_OFS = fill_t'(DELAY + WINDOW);
  localparam wsum_t MAX_SUM   = wsum_t'(WINDOW) * wsum_t'({LEVEL_W{1'b1}});

  ring_addr_t enter_addr;
  ring_addr_t leave_addr;
  level_t     enter_rd;
  level_t     leave_rd;
  level_t     enter_val;
  level_t     leave_val;
  level_t     x_r;
  logic       enter_ok_r;
  logic       leave_ok_r;
  wsum_t      sum_r;

  assign enter_addr = ptr - ENTER_OFS[RING_AW-1:0];
  assign leave_addr = ptr - LEAVE_OFS[RING_AW-1:0];

  dwpr_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (ctl.push),
    .waddr   (ptr),
    .wdata   (x),
    .re      (ctl.push),
    .raddr_a (enter_addr),
    .raddr_b (leave_addr),
    .rdata_a (enter_rd),
    .rdata_b (leave_rd)
  );

  // Entries older than the number of beats since reset were never written and count as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_ok_r <= 1'b0;
      leave_ok_r <= 1'b0;
    end else if (ctl.push) begin
      enter_ok_r <= (fill >= ENTER_OFS);
      leave_ok_r <= (fill >= LEAVE_OFS);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      x_r <= x;
    end
  end

  // With no delay the current beat enters the window directly.
  assign enter_val = (DELAY == 0) ? x_r : (enter_ok_r ? enter_rd : '0);
  assign leave_val = leave_ok_r ? leave_rd : '0;
  assign sum_o     = sum_r + wsum_t'(enter_val) - wsum_t'(leave_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.pop) begin
      sum_r <= sum_o;
    end
  end

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= MAX_SUM)
    else $error("window running sum exceeds the window capacity");

  a_leave_after_enter: assert property (@(posedge clk) disable iff (!rst_n)
    leave_ok_r |-> enter_ok_r)
    else $error("leaving entry valid while entering entry is not");

endmodule

// File: rtl/dwpr_regulate.sv
module dwpr_regulate import dwpr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  wsum_t        notch_sum,
  input  wsum_t        recep_sum,
  input  level_t       ligand_in,
  input  actin_t       actin_in,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,
  output logic [0:0]   out_tuser
);

  logic s2_v_r;
  logic s3_v_r;
  logic out_v_r;
  logic s3_rdy;
  logic out_rdy;

  logic [PROD_W-1:0]   notch_prod;
  logic [PROD_W-1:0]   recep_prod;
  logic [SCALED_W-1:0] s2_reduction_r;
  logic [SCALED_W-1:0] s2_addend_r;
  level_t              s2_ligand_r;
  actin_t              s2_actin_r;
  wsum_t               s2_nsum_r;
  wsum_t               s2_rsum_r;

  level_t              receptor_nxt;
  level_t              ligand_nxt;
  level_t              rec_diff;
  logic [SCALED_W:0]   ligand_wide;
  level_t              s3_receptor_r;
  level_t              s3_ligand_r;
  actin_t              s3_actin_r;
  wsum_t               s3_nsum_r;
  wsum_t               s3_rsum_r;

  logic                tip_nxt;
  level_t              out_receptor_r;
  level_t              out_ligand_r;
  wsum_t               out_nsum_r;
  wsum_t               out_rsum_r;
  logic                out_tip_r;

  assign out_rdy  = !out_v_r || out_tready;
  assign s3_rdy   = !s3_v_r || out_rdy;
  assign in_ready = !s2_v_r || s3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s2_v_r <= in_valid;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
      if (out_rdy) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  // Gains are Q4.12, so the products drop their twelve fraction bits.
  assign notch_prod = PROD_W'(notch_sum) * PROD_W'(cfg.notch_gain);
  assign recep_prod = PROD_W'(recep_sum) * PROD_W'(cfg.ligand_gain);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s2_reduction_r <= notch_prod[PROD_W-1:FRAC_W];
      s2_addend_r    <= recep_prod[PROD_W-1:FRAC_W];
      s2_ligand_r    <= ligand_in;
      s2_actin_r     <= actin_in;
      s2_nsum_r      <= notch_sum;
      s2_rsum_r      <= recep_sum;
    end
  end

  assign rec_diff    = cfg.receptor_norm - s2_reduction_r[LEVEL_W-1:0];
  assign ligand_wide = (SCALED_W+1)'(s2_ligand_r) + (SCALED_W+1)'(s2_addend_r);

  always_comb begin
    // A reduction larger than the norm would go negative; the floor takes over.
    if (s2_reduction_r > SCALED_W'(cfg.receptor_norm)) begin
      receptor_nxt = cfg.receptor_floor;
    end else if (rec_diff < cfg.receptor_floor) begin
      receptor_nxt = cfg.receptor_floor;
    end else begin
      receptor_nxt = rec_diff;
    end
    if (ligand_wide > (SCALED_W+1)'(cfg.ligand_ceiling)) begin
      ligand_nxt = cfg.ligand_ceiling;
    end else begin
      ligand_nxt = ligand_wide[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s3_rdy) begin
      s3_receptor_r <= receptor_nxt;
      s3_ligand_r   <= ligand_nxt;
      s3_actin_r    <= s2_actin_r;
      s3_nsum_r     <= s2_nsum_r;
      s3_rsum_r     <= s2_rsum_r;
    end
  end

  // The half-norm test is exact: twice the receptor total against the norm.
  assign tip_nxt = ({s3_receptor_r, 1'b0} > {1'b0, cfg.receptor_norm})
                   && (s3_actin_r >= cfg.actin_limit);

  always_ff @(posedge clk) begin
    if (s3_v_r && out_rdy) begin
      out_receptor_r <= s3_receptor_r;
      out_ligand_r   <= s3_ligand_r;
      out_nsum_r     <= s3_nsum_r;
      out_rsum_r     <= s3_rsum_r;
      out_tip_r      <= tip_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_rsum_r, out_nsum_r, out_ligand_r, out_receptor_r};
  assign out_tuser  = out_tip_r;

  a_s3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !out_rdy |=> s3_v_r)
    else $error("stage three item lost while the output register is stalled");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !s3_rdy |=> s2_v_r && $stable(s2_reduction_r))
    else $error("stage two item changed while stalled");

endmodule

// File: rtl/delayed_window_protein_regulator_unit.sv
// Delayed-window protein regulator.
// Input stream in_*: one beat per simulation tick of a cell, carrying summed active
// notch, summed active receptor, ligand held by agents and actin in use.
// Output stream out_*: one result beat per input beat, in order: regulated receptor
// total, clamped ligand total, both delayed window sums, and the tip cell flag in tuser.
// Configuration port cfg_*: one register write per beat, always ready; writes to an
// index beyond the register list are dropped. Write only while no tick is in flight.
// Throughput is one beat per cycle while the receiver takes results. Each result passes
// through the ring read, gain multiply, clamp and output register in that order. Each
// history ring is a 256-entry memory read at two addresses and written at one per beat,
// and the running sum it feeds closes through a single register, which sets that rate.
// Reset clears the running sums, the ring pointer, the count of beats since reset and
// the registers to their defaults; unwritten history reads as zero through that count,
// so there is no clearing pass and the block is ready as soon as reset is released.
// When the receiver stalls the output register holds its beat, the stages behind it
// keep filling, and in_tready falls once all four stages hold an item.
module delayed_window_protein_regulator_unit import dwpr_pkg::*; #(
  parameter int NOTCH_DELAY     = 16,
  parameter int NOTCH_WINDOW    = 16,
  parameter int RECEPTOR_DELAY  = 16,
  parameter int RECEPTOR_WINDOW = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  // active_notch_total[31:0], active_receptor_total[63:32],
  // ligand_agent_total[95:64], actin_used[111:96]
  input  logic [111:0]   in_tdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  // receptor_total[31:0], ligand_total[63:32], notch_effect[103:64],
  // receptor_effect[143:104]
  output logic [143:0]   out_tdata,
  // tip_cell[0]
  output logic [0:0]     out_tuser,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  cfg_idx_t       cfg_index,
  input  level_t         cfg_data
);

  cfg_t       cfg_r;
  ring_addr_t ptr_r;
  ring_addr_t ptr_nxt;
  fill_t      fill_r;
  fill_t      fill_nxt;
  logic       s1_v_r;
  logic       s1_v_nxt;
  level_t     s1_ligand_r;
  actin_t     s1_actin_r;
  logic       in_acc;
  logic       s2_rdy;
  win_ctl_t   win_ctl;
  wsum_t      notch_sum;
  wsum_t      recep_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.receptor_norm  <= RST_RECEPTOR_NORM;
      cfg_r.receptor_floor <= RST_RECEPTOR_FLOOR;
      cfg_r.notch_gain     <= RST_NOTCH_GAIN;
      cfg_r.ligand_gain    <= RST_LIGAND_GAIN;
      cfg_r.ligand_ceiling <= RST_LIGAND_CEILING;
      cfg_r.actin_limit    <= RST_ACTIN_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RECEPTOR_NORM:  cfg_r.receptor_norm  <= cfg_data;
        CFG_RECEPTOR_FLOOR: cfg_r.receptor_floor <= cfg_data;
        CFG_NOTCH_GAIN:     cfg_r.notch_gain     <= cfg_data[GAIN_W-1:0];
        CFG_LIGAND_GAIN:    cfg_r.ligand_gain    <= cfg_data[GAIN_W-1:0];
        CFG_LIGAND_CEILING: cfg_r.ligand_ceiling <= cfg_data;
        CFG_ACTIN_LIMIT:    cfg_r.actin_limit    <= cfg_data[ACTIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !s1_v_r || s2_rdy;
  assign in_acc    = in_tvalid && in_tready;
  assign win_ctl.push = in_acc;
  assign win_ctl.pop  = s1_v_r && s2_rdy;

  always_comb begin
    ptr_nxt  = ptr_r;
    fill_nxt = fill_r;
    s1_v_nxt = s1_v_r;
    if (win_ctl.pop) begin
      s1_v_nxt = 1'b0;
    end
    if (in_acc) begin
      s1_v_nxt = 1'b1;
      ptr_nxt  = ptr_r + 1'b1;
      // The beat count saturates at the ring depth: from then on every entry is written.
      if (fill_r != fill_t'(RING_DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      ptr_r  <= ptr_nxt;
      fill_r <= fill_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ligand_r <= in_tdata[95:64];
      s1_actin_r  <= in_tdata[111:96];
    end
  end

  dwpr_window #(
    .DELAY  (NOTCH_DELAY),
    .WINDOW (NOTCH_WINDOW)
  ) u_notch_win (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (win_ctl),
    .ptr   (ptr_r),
    .fill  (fill_r),
    .x     (in_tdata[31:0]),
    .sum_o (notch_sum)
  );

  dwpr_window #(
    .DELAY  (RECEPTOR_DELAY),
    .WINDOW (RECEPTOR_WINDOW)
  ) u_recep_win (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (win_ctl),
    .ptr   (ptr_r),
    .fill  (fill_r),
    .x     (in_tdata[63:32]),
    .sum_o (recep_sum)
  );

  dwpr_regulate u_regulate (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (s1_v_r),
    .in_ready   (s2_rdy),
    .notch_sum  (notch_sum),
    .recep_sum  (recep_sum),
    .ligand_in  (s1_ligand_r),
    .actin_in   (s1_actin_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= fill_t'(RING_DEPTH))
    else $error("beat count ran past the ring depth");

  a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != fill_t'(RING_DEPTH) |-> ptr_r == fill_r[RING_AW-1:0])
    else $error("ring pointer and beat count disagree before saturation");

endmodule
